[src/sic_pkg.sv]
// Package for the segment intersection core: coordinate width, derived widths
// and the stage record of the divider pipeline.
// Used by segment_intersection_core; depends on nothing.
package sic_pkg;

    // Coordinate width, legal range 8 to 20.
    localparam int COORD_WIDTH = 16;

    localparam int CW = COORD_WIDTH;        // coordinate and direction width
    localparam int DW = CW + 1;             // width of q - p
    localparam int PW = 2 * CW;             // product of two coordinates
    localparam int RW = 2 * CW + 1;         // r x s
    localparam int TW = 2 * CW + 2;         // (q - p) x s and (q - p) x r
    localparam int MW = 2 * CW;             // magnitude of r x s, divider remainder
    localparam int NW = 3 * CW;             // dividend |tn| * |r|
    localparam int OW = CW + 1;             // output coordinate width

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [OW-1:0] out_coord_t;

    // One stage of the restoring divider. The upper part of the dividend sits
    // in rem, the bits not yet used in low; quotient bits shift in at the
    // bottom of low, so after CW stages low holds the quotient.
    typedef struct packed {
        logic          hit;
        logic          neg_x;
        logic          neg_y;
        logic [CW-1:0] px;
        logic [CW-1:0] py;
        logic [MW-1:0] den;
        logic [MW-1:0] rem_x;
        logic [CW-1:0] low_x;
        logic [MW-1:0] rem_y;
        logic [CW-1:0] low_y;
    } div_stage_t;

endpackage

[src/segment_intersection_core.sv]
// Segment intersection core: cross products, unit-range tests and the
// intersection point through a pipelined restoring divider.
// Depends on sic_pkg.
//
//  Channel | Handshake         | Beat contents
//  --------+-------------------+------------------------------------------------
//  in      | in_valid/in_stall | first/second start and direction, x and y
//  out     | out_valid/out_stall | hit, cross_x, cross_y
//
// A beat is accepted on every cycle in which in_stall is low, and passes through
// COORD_WIDTH + 6 register stages: five arithmetic stages, one divider stage per
// quotient bit, and the output register. The divider chain sets the latency.
// A stalled output freezes the whole pipeline; in_stall is high exactly then.
// Reset clears the valid bits only.
module segment_intersection_core
    import sic_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic signed [CW-1:0]   first_start_x,
    input  logic signed [CW-1:0]   first_start_y,
    input  logic signed [CW-1:0]   first_dir_x,
    input  logic signed [CW-1:0]   first_dir_y,
    input  logic signed [CW-1:0]   second_start_x,
    input  logic signed [CW-1:0]   second_start_y,
    input  logic signed [CW-1:0]   second_dir_x,
    input  logic signed [CW-1:0]   second_dir_y,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   hit,
    output logic signed [OW-1:0]   cross_x,
    output logic signed [OW-1:0]   cross_y
);

    logic adv;

    // Stage 1: operands and q - p.
    logic                 s1_valid_reg;
    coord_t               s1_px_reg, s1_py_reg, s1_rx_reg, s1_ry_reg;
    coord_t               s1_sx_reg, s1_sy_reg;
    logic signed [DW-1:0] s1_dx_reg, s1_dy_reg;
    logic signed [DW-1:0] s1_dx_next, s1_dy_next;

    // Stage 2: the six products.
    logic                 s2_valid_reg;
    coord_t               s2_px_reg, s2_py_reg, s2_rx_reg, s2_ry_reg;
    logic signed [PW-1:0] s2_rxsy_reg, s2_rysx_reg;
    logic signed [PW:0]   s2_dxsy_reg, s2_dysx_reg, s2_dxry_reg, s2_dyrx_reg;
    logic signed [PW-1:0] s2_rxsy_next, s2_rysx_next;
    logic signed [PW:0]   s2_dxsy_next, s2_dysx_next, s2_dxry_next, s2_dyrx_next;

    // Stage 3: the three cross products.
    logic                 s3_valid_reg;
    coord_t               s3_px_reg, s3_py_reg, s3_rx_reg, s3_ry_reg;
    logic signed [RW-1:0] s3_rs_reg;
    logic signed [TW-1:0] s3_tn_reg, s3_un_reg;
    logic signed [RW-1:0] s3_rs_next;
    logic signed [TW-1:0] s3_tn_next, s3_un_next;

    // Stage 4: hit decision, magnitudes and quotient signs.
    logic                 s4_valid_reg;
    logic                 s4_hit_reg, s4_neg_x_reg, s4_neg_y_reg;
    coord_t               s4_px_reg, s4_py_reg;
    logic [MW-1:0]        s4_tmag_reg, s4_dmag_reg;
    logic [CW-1:0]        s4_rxmag_reg, s4_rymag_reg;
    logic                 s4_hit_next, s4_neg_x_next, s4_neg_y_next;
    logic [MW-1:0]        s4_tmag_next, s4_dmag_next;
    logic [CW-1:0]        s4_rxmag_next, s4_rymag_next;

    // Stage 5 (divider stage 0) and the divider chain.
    logic [CW:0]          div_valid_reg;
    div_stage_t           div_reg  [CW+1];
    div_stage_t           div_next [CW+1];

    // Output register.
    logic                 out_valid_reg;
    logic                 hit_reg;
    out_coord_t           cross_x_reg, cross_y_reg;
    logic                 hit_next;
    out_coord_t           cross_x_next, cross_y_next;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    //----------------------------------------------------------------------
    // Valid bits
    //----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            div_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            div_valid_reg <= {div_valid_reg[CW-1:0], s4_valid_reg};
            out_valid_reg <= div_valid_reg[CW];
        end
    end

    //----------------------------------------------------------------------
    // Stages 1 to 4
    //----------------------------------------------------------------------
    always_comb
    begin
        s1_dx_next = DW'(second_start_x) - DW'(first_start_x);
        s1_dy_next = DW'(second_start_y) - DW'(first_start_y);
    end

    always_comb
    begin
        s2_rxsy_next = s1_rx_reg * s1_sy_reg;
        s2_rysx_next = s1_ry_reg * s1_sx_reg;
        s2_dxsy_next = s1_dx_reg * s1_sy_reg;
        s2_dysx_next = s1_dy_reg * s1_sx_reg;
        s2_dxry_next = s1_dx_reg * s1_ry_reg;
        s2_dyrx_next = s1_dy_reg * s1_rx_reg;
    end

    always_comb
    begin
        s3_rs_next = RW'(s2_rxsy_reg) - RW'(s2_rysx_reg);
        s3_tn_next = TW'(s2_dxsy_reg) - TW'(s2_dysx_reg);
        s3_un_next = TW'(s2_dxry_reg) - TW'(s2_dyrx_reg);
    end

    always_comb
    begin
        logic                 rs_pos;
        logic                 t_ok;
        logic                 u_ok;
        logic signed [TW-1:0] rs_ext;
        logic [TW-1:0]        tn_abs;
        logic [RW-1:0]        rs_abs;
        logic [CW-1:0]        rx_abs;
        logic [CW-1:0]        ry_abs;

        rs_ext = TW'(s3_rs_reg);
        rs_pos = !s3_rs_reg[RW-1];
        // t = tn / rs and u = un / rs must lie in [0, 1].
        if (rs_pos)
        begin
            t_ok = !s3_tn_reg[TW-1] && (s3_tn_reg <= rs_ext);
            u_ok = !s3_un_reg[TW-1] && (s3_un_reg <= rs_ext);
        end
        else
        begin
            t_ok = (s3_tn_reg <= 0) && (s3_tn_reg >= rs_ext);
            u_ok = (s3_un_reg <= 0) && (s3_un_reg >= rs_ext);
        end
        s4_hit_next = (s3_rs_reg != '0) && t_ok && u_ok;

        tn_abs = s3_tn_reg[TW-1] ? TW'(-s3_tn_reg) : TW'(s3_tn_reg);
        rs_abs = s3_rs_reg[RW-1] ? RW'(-s3_rs_reg) : RW'(s3_rs_reg);
        rx_abs = s3_rx_reg[CW-1] ? CW'(-s3_rx_reg) : CW'(s3_rx_reg);
        ry_abs = s3_ry_reg[CW-1] ? CW'(-s3_ry_reg) : CW'(s3_ry_reg);

        // On a hit |tn| <= |rs| < 2^(2*CW-1), so the part-selects keep all of it.
        s4_tmag_next  = tn_abs[MW-1:0];
        s4_dmag_next  = rs_abs[MW-1:0];
        s4_rxmag_next = rx_abs;
        s4_rymag_next = ry_abs;
        s4_neg_x_next = s3_tn_reg[TW-1] ^ s3_rs_reg[RW-1] ^ s3_rx_reg[CW-1];
        s4_neg_y_next = s3_tn_reg[TW-1] ^ s3_rs_reg[RW-1] ^ s3_ry_reg[CW-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_px_reg    <= first_start_x;
            s1_py_reg    <= first_start_y;
            s1_rx_reg    <= first_dir_x;
            s1_ry_reg    <= first_dir_y;
            s1_sx_reg    <= second_dir_x;
            s1_sy_reg    <= second_dir_y;
            s1_dx_reg    <= s1_dx_next;
            s1_dy_reg    <= s1_dy_next;

            s2_px_reg    <= s1_px_reg;
            s2_py_reg    <= s1_py_reg;
            s2_rx_reg    <= s1_rx_reg;
            s2_ry_reg    <= s1_ry_reg;
            s2_rxsy_reg  <= s2_rxsy_next;
            s2_rysx_reg  <= s2_rysx_next;
            s2_dxsy_reg  <= s2_dxsy_next;
            s2_dysx_reg  <= s2_dysx_next;
            s2_dxry_reg  <= s2_dxry_next;
            s2_dyrx_reg  <= s2_dyrx_next;

            s3_px_reg    <= s2_px_reg;
            s3_py_reg    <= s2_py_reg;
            s3_rx_reg    <= s2_rx_reg;
            s3_ry_reg    <= s2_ry_reg;
            s3_rs_reg    <= s3_rs_next;
            s3_tn_reg    <= s3_tn_next;
            s3_un_reg    <= s3_un_next;

            s4_px_reg    <= s3_px_reg;
            s4_py_reg    <= s3_py_reg;
            s4_hit_reg   <= s4_hit_next;
            s4_neg_x_reg <= s4_neg_x_next;
            s4_neg_y_reg <= s4_neg_y_next;
            s4_tmag_reg  <= s4_tmag_next;
            s4_dmag_reg  <= s4_dmag_next;
            s4_rxmag_reg <= s4_rxmag_next;
            s4_rymag_reg <= s4_rymag_next;
        end
    end

    //----------------------------------------------------------------------
    // Stage 5: dividends |tn| * |r|, loaded into divider stage 0
    //----------------------------------------------------------------------
    always_comb
    begin
        logic [NW-1:0] num_x;
        logic [NW-1:0] num_y;

        num_x = s4_tmag_reg * s4_rxmag_reg;
        num_y = s4_tmag_reg * s4_rymag_reg;

        div_next[0].hit   = s4_hit_reg;
        div_next[0].neg_x = s4_neg_x_reg;
        div_next[0].neg_y = s4_neg_y_reg;
        div_next[0].px    = s4_px_reg;
        div_next[0].py    = s4_py_reg;
        div_next[0].den   = s4_dmag_reg;
        // The quotient is at most |r| < 2^CW, so the upper part is below den.
        div_next[0].rem_x = num_x[NW-1:CW];
        div_next[0].low_x = num_x[CW-1:0];
        div_next[0].rem_y = num_y[NW-1:CW];
        div_next[0].low_y = num_y[CW-1:0];
    end

    //----------------------------------------------------------------------
    // Divider chain: one quotient bit per stage, x and y side by side
    //----------------------------------------------------------------------
    for (genvar k = 1; k <= CW; k++)
    begin : g_div
        always_comb
        begin
            logic [MW:0] trial_x;
            logic [MW:0] trial_y;
            logic [MW:0] diff_x;
            logic [MW:0] diff_y;
            logic        ge_x;
            logic        ge_y;

            trial_x = {div_reg[k-1].rem_x, div_reg[k-1].low_x[CW-1]};
            trial_y = {div_reg[k-1].rem_y, div_reg[k-1].low_y[CW-1]};
            diff_x  = trial_x - {1'b0, div_reg[k-1].den};
            diff_y  = trial_y - {1'b0, div_reg[k-1].den};
            ge_x    = trial_x >= {1'b0, div_reg[k-1].den};
            ge_y    = trial_y >= {1'b0, div_reg[k-1].den};

            div_next[k]       = div_reg[k-1];
            div_next[k].rem_x = ge_x ? diff_x[MW-1:0] : trial_x[MW-1:0];
            div_next[k].rem_y = ge_y ? diff_y[MW-1:0] : trial_y[MW-1:0];
            div_next[k].low_x = {div_reg[k-1].low_x[CW-2:0], ge_x};
            div_next[k].low_y = {div_reg[k-1].low_y[CW-2:0], ge_y};
        end
    end

    for (genvar k = 0; k <= CW; k++)
    begin : g_div_reg
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    //----------------------------------------------------------------------
    // Output: apply the sign, add the start point
    //----------------------------------------------------------------------
    always_comb
    begin
        out_coord_t qx;
        out_coord_t qy;
        out_coord_t ox;
        out_coord_t oy;

        qx = out_coord_t'({1'b0, div_reg[CW].low_x});
        qy = out_coord_t'({1'b0, div_reg[CW].low_y});
        if (div_reg[CW].neg_x)
        begin
            qx = -qx;
        end
        if (div_reg[CW].neg_y)
        begin
            qy = -qy;
        end
        ox = out_coord_t'(coord_t'(div_reg[CW].px)) + qx;
        oy = out_coord_t'(coord_t'(div_reg[CW].py)) + qy;

        hit_next     = div_reg[CW].hit;
        cross_x_next = div_reg[CW].hit ? ox : '0;
        cross_y_next = div_reg[CW].hit ? oy : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg     <= hit_next;
            cross_x_reg <= cross_x_next;
            cross_y_reg <= cross_y_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign cross_x   = cross_x_reg;
    assign cross_y   = cross_y_reg;

endmodule

[dv/tb_segment_intersection_core.sv]
`timescale 1ns / 100ps
// Testbench for segment_intersection_core: a queue-fed driver, a checking monitor
// and a cross-product predictor of the intersection point. Depends on sic_pkg.
module tb_segment_intersection_core;
    import sic_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PAIRS = 450;
    localparam int HOLD_AT = 100;
    localparam int HOLD_LEN = 250;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        coord_t px;
        coord_t py;
        coord_t rx;
        coord_t ry;
        coord_t qx;
        coord_t qy;
        coord_t sx;
        coord_t sy;
        int     gap;
    } seg_pair_t;

    typedef struct {
        logic       hit;
        out_coord_t x;
        out_coord_t y;
    } crossing_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    coord_t     first_start_x;
    coord_t     first_start_y;
    coord_t     first_dir_x;
    coord_t     first_dir_y;
    coord_t     second_start_x;
    coord_t     second_start_y;
    coord_t     second_dir_x;
    coord_t     second_dir_y;
    logic       out_valid;
    logic       out_stall;
    logic       hit;
    out_coord_t cross_x;
    out_coord_t cross_y;

    seg_pair_t pending_pairs[$];
    crossing_t expected_crossings[$];
    seg_pair_t on_offer;
    int        idle_count;
    int        stall_left;
    int        results_seen;
    int        hold_count;
    logic      hold_active;
    int        mismatch_count;
    int        cycle_count;

    segment_intersection_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .first_start_x  (first_start_x),
        .first_start_y  (first_start_y),
        .first_dir_x    (first_dir_x),
        .first_dir_y    (first_dir_y),
        .second_start_x (second_start_x),
        .second_start_y (second_start_y),
        .second_dir_x   (second_dir_x),
        .second_dir_y   (second_dir_y),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .cross_x        (cross_x),
        .cross_y        (cross_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // True when the ratio num / den lies in [0, 1]; den is never zero here.
    function automatic logic in_unit_span(longint num, longint den);
        if (den > 0)
            return num >= 0 && num <= den;
        return num <= 0 && num >= den;
    endfunction

    function automatic crossing_t predict_crossing(seg_pair_t pr);
        crossing_t res;
        longint px, py, rx, ry, sx, sy, dx, dy, rs, tn, un;
        px = pr.px;
        py = pr.py;
        rx = pr.rx;
        ry = pr.ry;
        sx = pr.sx;
        sy = pr.sy;
        dx = longint'(pr.qx) - px;
        dy = longint'(pr.qy) - py;
        res.hit = 1'b0;
        res.x = '0;
        res.y = '0;
        rs = rx * sy - ry * sx;
        if (rs != 0)
        begin
            tn = dx * sy - dy * sx;
            un = dx * ry - dy * rx;
            if (in_unit_span(tn, rs) && in_unit_span(un, rs))
            begin
                // Signed division truncates toward zero, separately per axis.
                res.hit = 1'b1;
                res.x = out_coord_t'(px + (tn * rx) / rs);
                res.y = out_coord_t'(py + (tn * ry) / rs);
            end
        end
        return res;
    endfunction

    function automatic seg_pair_t make_pair(int px, int py, int rx, int ry,
                                            int qx, int qy, int sx, int sy);
        seg_pair_t pr;
        pr.px = coord_t'(px);
        pr.py = coord_t'(py);
        pr.rx = coord_t'(rx);
        pr.ry = coord_t'(ry);
        pr.qx = coord_t'(qx);
        pr.qy = coord_t'(qy);
        pr.sx = coord_t'(sx);
        pr.sy = coord_t'(sy);
        pr.gap = $urandom_range(0, 12);
        return pr;
    endfunction

    function automatic int spread(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // Mostly pairs built to cross near a chosen t and u, plus parallel pairs
    // and unconstrained full-range noise.
    function automatic seg_pair_t random_pair();
        seg_pair_t pr;
        int kind, den, kt, ku, m, lim_p, lim_d;
        int px, py, rx, ry, sx, sy;
        kind = $urandom_range(0, 9);
        pr = make_pair($urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
        if (kind == 2)
        begin
            rx = spread(1000);
            ry = spread(1000);
            m = spread(3);
            pr.rx = coord_t'(rx);
            pr.ry = coord_t'(ry);
            pr.sx = coord_t'(rx * m);
            pr.sy = coord_t'(ry * m);
        end
        else if (kind >= 3)
        begin
            lim_p = (kind == 9) ? 32767 : 16000;
            lim_d = (kind == 9) ? 32767 : 8000;
            px = spread(lim_p);
            py = spread(lim_p);
            rx = spread(lim_d);
            ry = spread(lim_d);
            sx = spread(lim_d);
            sy = spread(lim_d);
            den = $urandom_range(1, 8);
            kt = $urandom_range(0, den);
            ku = $urandom_range(0, den);
            pr = make_pair(px, py, rx, ry,
                           px + (rx * kt) / den - (sx * ku) / den,
                           py + (ry * kt) / den - (sy * ku) / den, sx, sy);
        end
        return pr;
    endfunction

    // Driver: the next pair waits out its gap, then is offered until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            first_start_x <= '0;
            first_start_y <= '0;
            first_dir_x <= '0;
            first_dir_y <= '0;
            second_start_x <= '0;
            second_start_y <= '0;
            second_dir_x <= '0;
            second_dir_y <= '0;
            idle_count = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_crossings.push_back(predict_crossing(on_offer));
            if (!in_valid || !in_stall)
            begin
                if (pending_pairs.size() != 0 && idle_count >= pending_pairs[0].gap)
                begin
                    on_offer = pending_pairs.pop_front();
                    first_start_x <= on_offer.px;
                    first_start_y <= on_offer.py;
                    first_dir_x <= on_offer.rx;
                    first_dir_y <= on_offer.ry;
                    second_start_x <= on_offer.qx;
                    second_start_y <= on_offer.qy;
                    second_dir_x <= on_offer.sx;
                    second_dir_y <= on_offer.sy;
                    in_valid <= 1'b1;
                    idle_count = 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (pending_pairs.size() != 0)
                        idle_count++;
                end
            end
        end
    end

    // One long hold-off on the result side so the pipeline fills and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_count <= 0;
        else if (hold_active)
            hold_count <= hold_count + 1;
    end

    assign hold_active = (results_seen >= HOLD_AT) && (hold_count < HOLD_LEN);

    // Monitor: checks each result beat against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : result_check
        crossing_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            results_seen <= 0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (expected_crossings.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected (hit %0d x %0d y %0d)",
                             $time, hit, cross_x, cross_y);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_crossings.pop_front();
                    if (hit !== want.hit)
                    begin
                        $display("%0t: hit expected %0d actual %0d", $time, want.hit, hit);
                        mismatch_count++;
                    end
                    if (cross_x !== want.x)
                    begin
                        $display("%0t: cross_x expected %0d actual %0d",
                                 $time, want.x, cross_x);
                        mismatch_count++;
                    end
                    if (cross_y !== want.y)
                    begin
                        $display("%0t: cross_y expected %0d actual %0d",
                                 $time, want.y, cross_y);
                        mismatch_count++;
                    end
                end
                stall_left = ((results_seen / 40) % 3 == 1) ? 0 : $urandom_range(0, 12);
            end
            out_stall <= hold_active || (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_segment_intersection_core: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;

        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767,
                                          32767, 32767, 32767, 32767));
        pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768,
                                          -32768, -32768, -32768, -32768));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, -5, 0, 10));
        // Hits at each end of either segment, then just outside.
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 0, -5, 0, 10));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 10, -5, 0, 10));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 0, 10));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, -10, 0, 10));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 11, -5, 0, 10));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 1, 0, 10));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, -1, -5, 0, 10));
        // Collinear and overlapping still counts as no crossing.
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 10, 0));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 0, 5, 10, 0));
        pending_pairs.push_back(make_pair(3, 3, 0, 0, 0, 0, 7, 9));
        pending_pairs.push_back(make_pair(5, -5, 0, 10, 0, 0, 10, 0));
        // A negative offset that floor division would round the other way.
        pending_pairs.push_back(make_pair(0, 0, -7, -3, -5, 1, 0, -6));
        pending_pairs.push_back(make_pair(0, 0, 7, 3, 5, -1, 0, 6));
        pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                          -32768, 32767, 32767, -32768));
        pending_pairs.push_back(make_pair(32767, 32767, -32768, -32768,
                                          32767, -32768, -32768, 32767));
        pending_pairs.push_back(make_pair(-32768, 0, -32768, 0,
                                          -32768, 32767, -32768, -32767));
        pending_pairs.push_back(make_pair(32767, 0, 32767, 0,
                                          32767, -32767, 32767, 32767));
        pending_pairs.push_back(make_pair(-32768, 32767, 32767, -32768,
                                          32767, -32768, -32768, 32767));

        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            pending_pairs.push_back(random_pair());
            // Every third block of forty beats is offered back to back.
            if ((i / 40) % 3 == 0)
                pending_pairs[pending_pairs.size() - 1].gap = 0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_pairs.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_crossings.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("tb_segment_intersection_core: done, clean");
        else
            $display("tb_segment_intersection_core: done, errors");
        $finish;
    end

endmodule

[files.f]
src/sic_pkg.sv
src/segment_intersection_core.sv
dv/tb_segment_intersection_core.sv
